FILE: rtl/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg
// shared constants, codes and types of the timer slot table
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

   localparam logic [2:0] CMD_CREATE  = 3'd0;
   localparam logic [2:0] CMD_CANCEL  = 3'd1;
   localparam logic [2:0] CMD_RESTART = 3'd2;
   localparam logic [2:0] CMD_QUERY   = 3'd3;
   localparam logic [2:0] CMD_TICK    = 3'd4;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_FIRED  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NULL    = 2'd1;
   localparam logic [1:0] ST_IN_USE  = 2'd2;
   localparam logic [1:0] ST_NO_SLOT = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_TCHECK,
      S_TFIRE,
      S_TDEC,
      S_TEND
   } state_type;

   typedef struct packed {
      logic        active;
      logic [7:0]  handle;
      logic [31:0] period;
      logic [31:0] deadline;
      logic [31:0] repeats;
   } slot_rd_type;

   typedef struct packed {
      logic              clear_en;
      logic [SLOT_W-1:0] clear_idx;
      logic              fill_en;
      logic [SLOT_W-1:0] fill_idx;
      logic [7:0]        handle;
      logic [31:0]       period;
      logic [31:0]       repeats;
      logic              dl_en;
      logic [SLOT_W-1:0] dl_idx;
      logic [31:0]       deadline;
      logic              rep_en;
      logic [SLOT_W-1:0] rep_idx;
      logic [31:0]       rep_value;
   } slot_wr_type;

endpackage

FILE: rtl/tst_alu.sv
// ----------------------------------------------------------------------------
// tst_alu
// shared 32-bit add/subtract unit used by the finish, tick-check, fire and decrement steps of the sequencer
// ----------------------------------------------------------------------------
module tst_alu (
   input  logic [31:0] alu_a,
   input  logic [31:0] alu_b,
   input  logic        alu_sub,
   output logic [31:0] alu_sum
);

   logic [31:0] b_op;

   assign b_op    = alu_sub ? ~alu_b : alu_b;
   assign alu_sum = alu_a + b_op + {31'd0, alu_sub};

endmodule

FILE: rtl/tst_store.sv
// ----------------------------------------------------------------------------
// tst_store
// slot register file: active bits and handles cleared by reset, timing
// fields written by create, restart and the tick pass, one read port
// ----------------------------------------------------------------------------
module tst_store (
   input  logic                       clock,
   input  logic                       reset,
   input  tst_pkg::slot_wr_type       wr,
   input  logic [tst_pkg::SLOT_W-1:0] rd_idx,
   output tst_pkg::slot_rd_type       rd
);

   logic [tst_pkg::TIMER_SLOTS-1:0] active_ff;
   logic [tst_pkg::TIMER_SLOTS-1:0] active_in;
   logic [7:0]  handle_ff   [tst_pkg::TIMER_SLOTS];
   logic [31:0] period_ff   [tst_pkg::TIMER_SLOTS];
   logic [31:0] deadline_ff [tst_pkg::TIMER_SLOTS];
   logic [31:0] repeats_ff  [tst_pkg::TIMER_SLOTS];

   // a fill after a clear of the same slot wins
   always_comb begin
      active_in = active_ff;
      if (wr.clear_en) begin
         active_in[wr.clear_idx] = 1'b0;
      end
      if (wr.fill_en) begin
         active_in[wr.fill_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < tst_pkg::TIMER_SLOTS; i++) begin
         if (reset) begin
            handle_ff[i] <= 8'd0;
         end else if (wr.fill_en && (int'(wr.fill_idx) == i)) begin
            handle_ff[i] <= wr.handle;
         end else if (wr.clear_en && (int'(wr.clear_idx) == i)) begin
            handle_ff[i] <= 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.fill_en) begin
         period_ff[wr.fill_idx]  <= wr.period;
         repeats_ff[wr.fill_idx] <= wr.repeats;
      end
      if (wr.rep_en) begin
         repeats_ff[wr.rep_idx] <= wr.rep_value;
      end
      if (wr.dl_en) begin
         deadline_ff[wr.dl_idx] <= wr.deadline;
      end
   end

   assign rd.active   = active_ff[rd_idx];
   assign rd.handle   = handle_ff[rd_idx];
   assign rd.period   = period_ff[rd_idx];
   assign rd.deadline = deadline_ff[rd_idx];
   assign rd.repeats  = repeats_ff[rd_idx];

endmodule

FILE: rtl/timer_slot_table.sv
// ----------------------------------------------------------------------------
// timer_slot_table
// table of timer slots keyed by nonzero handles: create, cancel, restart,
// query and a tick that fires every due slot in ascending order
// ----------------------------------------------------------------------------
// One word is taken at a time; req_ready is high only while the sequencer is
// idle. Every command but tick scans all TIMER_SLOTS slots, one per cycle through
// the single read port of the slot file, then uses the shared adder in S_FINISH
// to apply the change and load the status word. A tick checks each slot in turn
// in S_TCHECK with the due compare, goes to S_TFIRE for each fired slot to
// advance its deadline and load the fired word, to S_TDEC when a counted repeat
// is decremented, and to S_TEND for the end-of-tick word. A fired or status word
// waits
// in the output register while the sequencer goes on, so rsp_ready stalls the
// sequencer only when a second word is ready before the first is taken.
// ----------------------------------------------------------------------------
module timer_slot_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [31:0]        req_now_ms,
   input  logic [7:0]         req_callback_id,
   input  logic [31:0]        req_interval_ms,
   input  logic signed [31:0] req_repeat_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic [7:0]         rsp_fired_id,
   output logic [1:0]         rsp_status,
   output logic               rsp_is_active,
   output logic               rsp_last
);

   tst_pkg::state_type state_ff, state_in;

   logic [tst_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [31:0] now_ff, now_in;
   logic [7:0]  id_ff, id_in;
   logic [31:0] interval_ff, interval_in;
   logic [31:0] repeat_ff, repeat_in;

   logic match_found_ff, match_found_in;
   logic [tst_pkg::SLOT_W-1:0] match_idx_ff, match_idx_in;
   logic free_found_ff, free_found_in;
   logic [tst_pkg::SLOT_W-1:0] free_idx_ff, free_idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] fid_ff, fid_in;
   logic [1:0] status_ff, status_in;
   logic       act_ff, act_in;
   logic       last_ff, last_in;

   tst_pkg::slot_rd_type rd;
   tst_pkg::slot_wr_type wr;

   logic [31:0] alu_a, alu_b, alu_sum;
   logic        alu_sub;

   logic accept, out_free, last_idx, due, rep_more, hit, free_slot, rsp_load;
   logic null_id, do_fill, do_clear;
   logic [1:0] cmd_status;

   tst_alu u_alu (
      .alu_a   (alu_a),
      .alu_b   (alu_b),
      .alu_sub (alu_sub),
      .alu_sum (alu_sum)
   );

   tst_store u_store (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .rd_idx (idx_ff),
      .rd     (rd)
   );

   assign accept    = (state_ff == tst_pkg::S_IDLE) && req_valid;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_idx  = (idx_ff == tst_pkg::LAST_SLOT);
   assign due       = rd.active && !alu_sum[31];
   assign rep_more  = !rd.repeats[31] && (|rd.repeats[30:1]);
   assign hit       = rd.active && (rd.handle == id_ff);
   assign free_slot = !rd.active || ((cmd_ff == tst_pkg::CMD_RESTART) && hit);
   assign null_id   = (id_ff == 8'd0);

   // command outcome once the scan is done
   always_comb begin
      cmd_status = tst_pkg::ST_OK;
      do_fill    = 1'b0;
      do_clear   = 1'b0;
      case (cmd_ff)
         tst_pkg::CMD_CREATE: begin
            if (null_id) begin
               cmd_status = tst_pkg::ST_NULL;
            end else if (match_found_ff) begin
               cmd_status = tst_pkg::ST_IN_USE;
            end else if (!free_found_ff) begin
               cmd_status = tst_pkg::ST_NO_SLOT;
            end else begin
               do_fill = 1'b1;
            end
         end
         tst_pkg::CMD_CANCEL: begin
            if (null_id) begin
               cmd_status = tst_pkg::ST_NULL;
            end else begin
               do_clear = match_found_ff;
            end
         end
         tst_pkg::CMD_RESTART: begin
            if (null_id) begin
               cmd_status = tst_pkg::ST_NULL;
            end else begin
               do_clear = match_found_ff;
               if (!free_found_ff) begin
                  cmd_status = tst_pkg::ST_NO_SLOT;
               end else begin
                  do_fill = 1'b1;
               end
            end
         end
         tst_pkg::CMD_QUERY: begin
            if (null_id) begin
               cmd_status = tst_pkg::ST_NULL;
            end
         end
         default: begin
            cmd_status = tst_pkg::ST_OK;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tst_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = (req_command == tst_pkg::CMD_TICK) ? tst_pkg::S_TCHECK
                                                             : tst_pkg::S_SCAN;
            end
         end
         tst_pkg::S_SCAN: begin
            if (last_idx) begin
               state_in = tst_pkg::S_FINISH;
            end
         end
         tst_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = tst_pkg::S_IDLE;
            end
         end
         tst_pkg::S_TCHECK: begin
            if (due) begin
               state_in = tst_pkg::S_TFIRE;
            end else if (last_idx) begin
               state_in = tst_pkg::S_TEND;
            end
         end
         tst_pkg::S_TFIRE: begin
            if (out_free) begin
               if (rep_more) begin
                  state_in = tst_pkg::S_TDEC;
               end else if (last_idx) begin
                  state_in = tst_pkg::S_TEND;
               end else begin
                  state_in = tst_pkg::S_TCHECK;
               end
            end
         end
         tst_pkg::S_TDEC: begin
            state_in = last_idx ? tst_pkg::S_TEND : tst_pkg::S_TCHECK;
         end
         tst_pkg::S_TEND: begin
            if (out_free) begin
               state_in = tst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tst_pkg::S_IDLE;
         end
      endcase
   end

   // outputs: adder operands, slot writes, result word
   always_comb begin
      req_ready = 1'b0;
      alu_a     = now_ff;
      alu_b     = interval_ff;
      alu_sub   = 1'b0;
      wr        = '0;
      rsp_load  = 1'b0;
      kind_in   = tst_pkg::KIND_STATUS;
      fid_in    = 8'd0;
      status_in = tst_pkg::ST_OK;
      act_in    = 1'b0;
      last_in   = 1'b0;
      case (state_ff)
         tst_pkg::S_IDLE: begin
            req_ready = 1'b1;
         end
         tst_pkg::S_FINISH: begin
            rsp_load     = out_free;
            kind_in      = tst_pkg::KIND_STATUS;
            fid_in       = id_ff;
            status_in    = cmd_status;
            act_in       = (cmd_ff == tst_pkg::CMD_QUERY) && !null_id && match_found_ff;
            last_in      = 1'b1;
            wr.clear_en  = out_free && do_clear;
            wr.clear_idx = match_idx_ff;
            wr.fill_en   = out_free && do_fill;
            wr.fill_idx  = free_idx_ff;
            wr.handle    = id_ff;
            wr.period    = interval_ff;
            wr.repeats   = repeat_ff;
            wr.dl_en     = out_free && do_fill;
            wr.dl_idx    = free_idx_ff;
            wr.deadline  = alu_sum;
         end
         tst_pkg::S_TCHECK: begin
            alu_a   = now_ff;
            alu_b   = rd.deadline;
            alu_sub = 1'b1;
         end
         tst_pkg::S_TFIRE: begin
            alu_a        = rd.deadline;
            alu_b        = rd.period;
            rsp_load     = out_free;
            kind_in      = tst_pkg::KIND_FIRED;
            fid_in       = rd.handle;
            wr.dl_en     = out_free;
            wr.dl_idx    = idx_ff;
            wr.deadline  = alu_sum;
            wr.clear_en  = out_free && (rd.repeats == 32'd1);
            wr.clear_idx = idx_ff;
         end
         tst_pkg::S_TDEC: begin
            alu_a        = rd.repeats;
            alu_b        = 32'd1;
            alu_sub      = 1'b1;
            wr.rep_en    = 1'b1;
            wr.rep_idx   = idx_ff;
            wr.rep_value = alu_sum;
         end
         tst_pkg::S_TEND: begin
            rsp_load = out_free;
            kind_in  = tst_pkg::KIND_END;
            last_in  = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // scan index, latched word and scan results
   always_comb begin
      idx_in         = idx_ff;
      cmd_in         = cmd_ff;
      now_in         = now_ff;
      id_in          = id_ff;
      interval_in    = interval_ff;
      repeat_in      = repeat_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      if (accept) begin
         idx_in         = '0;
         cmd_in         = req_command;
         now_in         = req_now_ms;
         id_in          = req_callback_id;
         interval_in    = req_interval_ms;
         repeat_in      = $unsigned(req_repeat_count);
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end
      if (state_ff == tst_pkg::S_SCAN) begin
         if (hit) begin
            match_found_in = 1'b1;
            match_idx_in   = idx_ff;
         end
         if (free_slot && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = idx_ff;
         end
      end
      if (!last_idx && ((state_ff == tst_pkg::S_SCAN) ||
                        ((state_ff == tst_pkg::S_TCHECK) && !due) ||
                        ((state_ff == tst_pkg::S_TFIRE) && out_free && !rep_more) ||
                        (state_ff == tst_pkg::S_TDEC))) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tst_pkg::S_IDLE;
         rsp_valid_ff   <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         idx_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         idx_ff         <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      now_ff       <= now_in;
      id_ff        <= id_in;
      interval_ff  <= interval_in;
      repeat_ff    <= repeat_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      if (rsp_load) begin
         kind_ff   <= kind_in;
         fid_ff    <= fid_in;
         status_ff <= status_in;
         act_ff    <= act_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_fired_id    = fid_ff;
   assign rsp_status      = status_ff;
   assign rsp_is_active   = act_ff;
   assign rsp_last        = last_ff;

endmodule
